// ===== hw/rtl/lwsh_pkg.sv =====
package lwsh_pkg;

  // hash constants
  localparam longint unsigned WORD_MULT = 64'd11261;
  localparam longint unsigned WORD_MOD  = 64'd46301;
  localparam longint unsigned SENT_MULT = 64'd2350001;
  localparam longint unsigned SENT_MOD  = 64'd99999989;

  // words folded into the sentence hash per line
  localparam int unsigned MAX_WORDS = 8;

  // ascii letter bounds
  localparam logic [7:0] CHAR_UPPER_FIRST = 8'h41;
  localparam logic [7:0] CHAR_UPPER_LAST  = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_FIRST = 8'h61;
  localparam logic [7:0] CHAR_LOWER_LAST  = 8'h7a;

  localparam logic [7:0] WORD_LEN_MAX = 8'hff;

  // reduction thresholds for the word and sentence sums
  localparam logic [17:0] WORD_MOD_X1 = 18'(WORD_MOD);
  localparam logic [17:0] WORD_MOD_X2 = 18'(2 * WORD_MOD);
  localparam logic [28:0] SENT_MOD_X1 = 29'(SENT_MOD);
  localparam logic [28:0] SENT_MOD_X2 = 29'(2 * SENT_MOD);
  localparam logic [28:0] SENT_MOD_X3 = 29'(3 * SENT_MOD);
  localparam logic [28:0] SENT_MOD_X4 = 29'(4 * SENT_MOD);

  typedef logic [15:0] word_tab_t [256];
  typedef logic [26:0] sent_tab_t [256];

  // entry i holds (i * scale * WORD_MULT) mod WORD_MOD
  function automatic word_tab_t build_word_tab(input longint unsigned scale);
    word_tab_t t;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v = (longint'(i) * scale * WORD_MULT) % WORD_MOD;
      t[i] = 16'(v);
    end
    return t;
  endfunction

  // entry i holds ((i << shift) * SENT_MULT) mod SENT_MOD
  function automatic sent_tab_t build_sent_tab(input int unsigned shift);
    sent_tab_t t;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v = ((longint'(i) << shift) * SENT_MULT) % SENT_MOD;
      t[i] = 27'(v);
    end
    return t;
  endfunction

  localparam word_tab_t WORD_LO_TAB = build_word_tab(64'd1);
  localparam word_tab_t WORD_HI_TAB = build_word_tab(64'd256);

  localparam sent_tab_t SENT_TAB0 = build_sent_tab(0);
  localparam sent_tab_t SENT_TAB1 = build_sent_tab(8);
  localparam sent_tab_t SENT_TAB2 = build_sent_tab(16);
  localparam sent_tab_t SENT_TAB3 = build_sent_tab(24);

  typedef struct packed {
    logic        inside_word;
    logic [15:0] word_hash;
    logic [7:0]  word_len;
    logic [26:0] sent_hash;
    logic [3:0]  kept_words;
    logic        overflow_seen;
  } lwsh_state_t;

  typedef struct packed {
    logic        word_done;
    logic [15:0] word_hash;
    logic [7:0]  word_length;
    logic        line_done;
    logic [26:0] sentence_hash;
    logic [3:0]  word_count;
    logic        word_overflow;
  } lwsh_result_t;

endpackage

// ===== hw/rtl/lwsh_if.sv =====
interface lwsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink (input valid, input text_byte, input line_end, output ready);
endinterface

interface lwsh_out_if;
  logic        valid;
  logic        ready;
  logic        word_done;
  logic [15:0] word_hash;
  logic [7:0]  word_length;
  logic        line_done;
  logic [26:0] sentence_hash;
  logic [3:0]  word_count;
  logic        word_overflow;

  modport source (
    output valid, output word_done, output word_hash, output word_length,
    output line_done, output sentence_hash, output word_count, output word_overflow,
    input ready
  );
  modport sink (
    input valid, input word_done, input word_hash, input word_length,
    input line_done, input sentence_hash, input word_count, input word_overflow,
    output ready
  );
endinterface

// ===== hw/rtl/lwsh_step.sv =====
module lwsh_step
  import lwsh_pkg::*;
(
  input  logic [7:0]   text_byte,
  input  logic         line_end,
  input  lwsh_state_t  state_cur,
  output lwsh_state_t  state_nxt,
  output lwsh_result_t result,
  output logic         emit
);

  logic        letter;
  logic [17:0] wsum;
  logic [15:0] wred;
  logic [15:0] hash_cur;
  logic [7:0]  len_cur;
  logic        in_word;
  logic        ended;
  logic        fold_en;
  logic [28:0] ssum;
  logic [26:0] sred;
  logic [26:0] sent_new;
  logic [3:0]  kept_new;
  logic        ovf_new;

  assign letter = ((text_byte >= CHAR_UPPER_FIRST) && (text_byte <= CHAR_UPPER_LAST)) ||
                  ((text_byte >= CHAR_LOWER_FIRST) && (text_byte <= CHAR_LOWER_LAST));

  // word hash step: h*mult split into two byte-wide table terms, sum below 3*mod
  assign wsum = 18'(WORD_LO_TAB[state_cur.word_hash[7:0]])
              + 18'(WORD_HI_TAB[state_cur.word_hash[15:8]])
              + 18'(text_byte);

  always_comb begin
    if (wsum >= WORD_MOD_X2) begin
      wred = 16'(wsum - WORD_MOD_X2);
    end else if (wsum >= WORD_MOD_X1) begin
      wred = 16'(wsum - WORD_MOD_X1);
    end else begin
      wred = 16'(wsum);
    end
  end

  assign hash_cur = letter ? wred : state_cur.word_hash;
  assign len_cur  = !letter ? state_cur.word_len :
                    (state_cur.word_len == WORD_LEN_MAX) ? WORD_LEN_MAX :
                    8'(state_cur.word_len + 8'd1);
  assign in_word  = state_cur.inside_word | letter;
  assign ended    = in_word & (!letter | line_end);
  assign fold_en  = ended & (state_cur.kept_words < 4'(MAX_WORDS));

  // sentence fold: four table terms of sh*mult plus the word hash, below 5*mod
  assign ssum = 29'(SENT_TAB0[state_cur.sent_hash[7:0]])
              + 29'(SENT_TAB1[state_cur.sent_hash[15:8]])
              + 29'(SENT_TAB2[state_cur.sent_hash[23:16]])
              + 29'(SENT_TAB3[{5'd0, state_cur.sent_hash[26:24]}])
              + 29'(hash_cur);

  always_comb begin
    if (ssum >= SENT_MOD_X4) begin
      sred = 27'(ssum - SENT_MOD_X4);
    end else if (ssum >= SENT_MOD_X3) begin
      sred = 27'(ssum - SENT_MOD_X3);
    end else if (ssum >= SENT_MOD_X2) begin
      sred = 27'(ssum - SENT_MOD_X2);
    end else if (ssum >= SENT_MOD_X1) begin
      sred = 27'(ssum - SENT_MOD_X1);
    end else begin
      sred = 27'(ssum);
    end
  end

  assign sent_new = fold_en ? sred : state_cur.sent_hash;
  assign kept_new = fold_en ? 4'(state_cur.kept_words + 4'd1) : state_cur.kept_words;
  assign ovf_new  = state_cur.overflow_seen | (ended & !fold_en);

  assign emit = ended | line_end;

  always_comb begin
    result.word_done     = ended;
    result.word_hash     = ended ? hash_cur : 16'd0;
    result.word_length   = ended ? len_cur : 8'd0;
    result.line_done     = line_end;
    result.sentence_hash = sent_new;
    result.word_count    = kept_new;
    result.word_overflow = ovf_new;
  end

  always_comb begin
    state_nxt = state_cur;
    if (line_end) begin
      state_nxt = '0;
    end else if (ended) begin
      state_nxt.inside_word   = 1'b0;
      state_nxt.word_hash     = 16'd0;
      state_nxt.word_len      = 8'd0;
      state_nxt.sent_hash     = sent_new;
      state_nxt.kept_words    = kept_new;
      state_nxt.overflow_seen = ovf_new;
    end else if (letter) begin
      state_nxt.inside_word = 1'b1;
      state_nxt.word_hash   = hash_cur;
      state_nxt.word_len    = len_cur;
    end
  end

endmodule

// ===== hw/rtl/line_word_sentence_hasher.sv =====
// line word and sentence hasher: takes a text line one byte per request and splits it
// into words (runs of ascii letters; any other byte, including 128..255, separates).
// each word is hashed as h = (h*11261 + byte) mod 46301 and its length counted,
// saturating at 255; a result leaves when a word ends or when line_end is set. the
// first eight words of a line are folded into a sentence hash
// s = (s*2350001 + h) mod 99999989; later words are still reported but only raise
// word_overflow. before line end a result carries the running sentence hash and count;
// the line-end result closes the line and clears the line state. throughput is one
// byte per cycle, but a byte that yields a result waits while the result register is full
// and not draining; a byte that yields no result never waits on the result side. a byte
// passes the input register, then the result register. the word hash loop (two byte-indexed
// constant tables, an add, a two-step reduction) and the sentence fold it feeds set the cycle time.
module line_word_sentence_hasher
  import lwsh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  lwsh_in_if.sink  in_ch,
  lwsh_out_if.source out_ch
);

  // input register
  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // running word and line state
  lwsh_state_t state_r;
  lwsh_state_t state_nxt;

  // result register
  logic         out_valid_r;
  logic         out_valid_nxt;
  lwsh_result_t out_res_r;

  lwsh_result_t step_res;
  logic         step_emit;
  logic         out_free;
  logic         advance;
  logic         in_take;

  lwsh_step u_step (
    .text_byte (in_byte_r),
    .line_end  (in_last_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (step_res),
    .emit      (step_emit)
  );

  // the result register frees up when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  // a byte without a result moves on regardless of the result side
  assign advance  = in_valid_r && (!step_emit || out_free);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && step_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.text_byte;
      in_last_r <= in_ch.line_end;
    end
    if (advance && step_emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.word_done     = out_res_r.word_done;
  assign out_ch.word_hash     = out_res_r.word_hash;
  assign out_ch.word_length   = out_res_r.word_length;
  assign out_ch.line_done     = out_res_r.line_done;
  assign out_ch.sentence_hash = out_res_r.sentence_hash;
  assign out_ch.word_count    = out_res_r.word_count;
  assign out_ch.word_overflow = out_res_r.word_overflow;

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import lwsh_pkg::*;

  // one byte of the line as queued for the driver
  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n;

  lwsh_in_if  in_ch ();
  lwsh_out_if out_ch ();

  line_word_sentence_hasher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 time unit period
  always #10 clk = ~clk;

  // bytes waiting to be offered, and the results the hasher should give back
  text_item_t   pending_bytes[$];
  lwsh_result_t expected_hashes[$];

  // predicted line state, following every accepted request
  lwsh_state_t line_state = '0;

  // idling percentages for the current phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned mismatch_count = 0;
  int unsigned queued_items;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CHAR_UPPER_FIRST && b <= CHAR_UPPER_LAST) ||
           (b >= CHAR_LOWER_FIRST && b <= CHAR_LOWER_LAST);
  endfunction

  // advance the predicted state by one byte; returns 1 when a result is due
  function automatic logic hash_text_byte(input logic [7:0] b, input logic last,
                                          output lwsh_result_t res);
    logic            letter;
    logic            ended;
    logic [15:0]     fin_hash;
    logic [7:0]      fin_len;
    longint unsigned acc;
    letter   = is_letter(b);
    ended    = 1'b0;
    fin_hash = '0;
    fin_len  = '0;
    res      = '0;

    // a letter extends the running word
    if (letter) begin
      line_state.inside_word = 1'b1;
      acc = line_state.word_hash;
      acc = (acc * WORD_MULT + longint'(b)) % WORD_MOD;
      line_state.word_hash = 16'(acc);
      if (line_state.word_len != WORD_LEN_MAX) begin
        line_state.word_len = line_state.word_len + 8'd1;
      end
    end

    // word closes on a separator, or on line end even if the last byte is a letter
    if (line_state.inside_word && (!letter || last)) begin
      ended    = 1'b1;
      fin_hash = line_state.word_hash;
      fin_len  = line_state.word_len;
      if (line_state.kept_words < MAX_WORDS) begin
        acc = line_state.sent_hash;
        acc = (acc * SENT_MULT + longint'(fin_hash)) % SENT_MOD;
        line_state.sent_hash  = 27'(acc);
        line_state.kept_words = line_state.kept_words + 4'd1;
      end else begin
        // words past the limit are reported but not folded in
        line_state.overflow_seen = 1'b1;
      end
      line_state.inside_word = 1'b0;
      line_state.word_hash   = '0;
      line_state.word_len    = '0;
    end

    if (!ended && !last) begin
      return 1'b0;
    end

    res.word_done     = ended;
    res.word_hash     = fin_hash;
    res.word_length   = fin_len;
    res.line_done     = last;
    res.sentence_hash = line_state.sent_hash;
    res.word_count    = line_state.kept_words;
    res.word_overflow = line_state.overflow_seen;

    // line end clears everything
    if (last) begin
      line_state = '0;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint unsigned exp_val,
                                      input longint unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the next queued byte, holding it until the request is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    text_item_t item;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.text_byte <= '0;
      in_ch.line_end  <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // previous request gone (or none), so a new one may be offered
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= item.text_byte;
        in_ch.line_end  <= item.line_end;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result taken, then predicts from each byte taken;
  // the two can't belong to the same byte in one cycle given the latency
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    lwsh_result_t exp_res;
    lwsh_result_t new_res;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected result, word_hash %0d line_done %0b", $time,
                   out_ch.word_hash, out_ch.line_done);
          mismatch_count++;
        end else begin
          exp_res = expected_hashes.pop_front();
          check_field("word_done", exp_res.word_done, out_ch.word_done);
          check_field("word_hash", exp_res.word_hash, out_ch.word_hash);
          check_field("word_length", exp_res.word_length, out_ch.word_length);
          check_field("line_done", exp_res.line_done, out_ch.line_done);
          check_field("sentence_hash", exp_res.sentence_hash, out_ch.sentence_hash);
          check_field("word_count", exp_res.word_count, out_ch.word_count);
          check_field("word_overflow", exp_res.word_overflow, out_ch.word_overflow);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (hash_text_byte(in_ch.text_byte, in_ch.line_end, new_res)) begin
          expected_hashes.push_back(new_res);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b, input logic last);
    text_item_t item;
    item.text_byte = b;
    item.line_end  = last;
    pending_bytes.push_back(item);
    queued_items++;
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) begin
      return 8'($urandom_range(CHAR_UPPER_FIRST, CHAR_UPPER_LAST));
    end
    return 8'($urandom_range(CHAR_LOWER_FIRST, CHAR_LOWER_LAST));
  endfunction

  // any non-letter, spaces favoured as in ordinary text
  function automatic logic [7:0] rand_separator();
    logic [7:0] b;
    if ($urandom_range(2) == 0) begin
      return 8'h20;
    end
    do begin
      b = 8'($urandom_range(255));
    end while (is_letter(b));
    return b;
  endfunction

  // well-formed line: words of letters split by separators; some lines overflow
  // the word limit, a rare word runs past the length ceiling
  task automatic add_text_line();
    int unsigned n_words;
    int unsigned word_len;
    int unsigned n_seps;
    logic        end_on_letter;
    logic        final_word;
    n_words       = ($urandom_range(3) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 8);
    end_on_letter = 1'($urandom_range(1));
    if (n_words == 0) begin
      n_seps = $urandom_range(1, 3);
      for (int unsigned s = 0; s < n_seps; s++) begin
        add_byte(rand_separator(), s == n_seps - 1);
      end
    end else begin
      if ($urandom_range(3) == 0) begin
        add_byte(rand_separator(), 1'b0);
      end
      for (int unsigned w = 0; w < n_words; w++) begin
        final_word = (w == n_words - 1);
        word_len   = ($urandom_range(199) == 0) ? $urandom_range(250, 300)
                                                : $urandom_range(1, 10);
        for (int unsigned i = 0; i < word_len; i++) begin
          add_byte(rand_letter(), final_word && end_on_letter && i == word_len - 1);
        end
        if (!(final_word && end_on_letter)) begin
          n_seps = $urandom_range(1, 3);
          for (int unsigned s = 0; s < n_seps; s++) begin
            add_byte(rand_separator(), final_word && s == n_seps - 1);
          end
        end
      end
    end
  endtask

  // noise: arbitrary bytes, closed by a line end
  task automatic add_noise_line();
    int unsigned n_bytes;
    n_bytes = $urandom_range(1, 20);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      add_byte(8'($urandom_range(255)), i == n_bytes - 1);
    end
  endtask

  // letter boundaries, extreme bytes, overflowing line ending on a letter,
  // line end with no word, word closed by the line-end separator, one-letter line
  task automatic add_directed_lines();
    logic [7:0] first_line[17];
    first_line = '{8'h41, 8'h40, 8'h5a, 8'h5b, 8'h61, 8'h60, 8'h7a, 8'h7b, 8'h4d,
                   8'h00, 8'h71, 8'hff, 8'h42, 8'h7f, 8'h79, 8'h80, 8'h4b};
    foreach (first_line[i]) begin
      add_byte(first_line[i], i == 16);
    end
    add_byte(8'h20, 1'b1);
    add_byte(8'h78, 1'b0);
    add_byte(8'h20, 1'b1);
    add_byte(8'h51, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // reset, phases and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    queued_items    = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      queued_items = 0;
      if (phase == 0) begin
        add_directed_lines();
      end
      while (queued_items < 462) begin
        if ($urandom_range(4) == 0) begin
          add_noise_line();
        end else begin
          add_text_line();
        end
      end
      // let the driver drain this phase before the idling changes
      while (pending_bytes.size() != 0) @(posedge clk);
    end

    while (in_ch.valid) @(posedge clk);
    while (expected_hashes.size() != 0) @(posedge clk);
    // once the input and result registers are empty, the extra wait shows any stray result
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #4000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_hashes.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
